FILE: hdl/sfr_pkg.sv
// Shared types, constants and helpers for the stuffed frame receiver.
// Used by the front end, the back end and the top level. No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

   // Default payload length and the number of payload bytes shown on the result
   localparam int PAYLOAD_BYTES_DEF = 7;
   localparam int FIELD_BYTES       = 7;
   localparam int SLOT_W            = $clog2(FIELD_BYTES);

   // Depth of the queues between front and back and on the result side
   localparam int QUEUE_DEPTH = 2;

   // Control register file
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_BYTE = 2'd0,
      CSR_STUFF_BYTE = 2'd1,
      CSR_XOR_MASK   = 2'd2
   } csr_index_type;

   localparam logic [7:0] START_BYTE_RST = 8'd126;
   localparam logic [7:0] STUFF_BYTE_RST = 8'd125;
   localparam logic [7:0] XOR_MASK_RST   = 8'd32;
   localparam logic [7:0] CHECKSUM_BASE  = 8'hFF;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] stuff_byte;
      logic [7:0] xor_mask;
   } cfg_type;

   // Front end framing phase
   typedef enum logic [1:0] {
      PH_COLLECT,
      PH_ESCAPED,
      PH_CHECKSUM,
      PH_DONE
   } phase_type;

   // Operations handed from front to back
   typedef enum logic [1:0] {
      OP_RESTART,
      OP_DATA,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        data;
      logic [SLOT_W-1:0] slot;
      logic              slot_ok;
   } item_type;

   typedef struct packed {
      logic        frame_ok;
      logic [7:0]  frame_type;
      logic [15:0] value_key;
      logic [31:0] value_data;
      logic [7:0]  got_checksum;
      logic [7:0]  want_checksum;
   } result_type;

   // Fold the carry byte into the low byte, then complement against 0xFF
   function automatic logic [7:0] checksum_of(input logic [15:0] sum);
      logic [7:0] fold;
      fold = sum[7:0] + sum[15:8];
      return CHECKSUM_BASE - fold;
   endfunction

endpackage

FILE: hdl/sfr_fifo.sv
// Small register-based queue used between the front and back ends
// and on the result side. Depends on nothing.
`timescale 1ns / 1ps

module sfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Advance pointers and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue occupancy beyond depth");

   a_pop_only_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue occupancy did not drop on pop");

   a_push_only_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue occupancy did not rise on push");
`endif

endmodule

FILE: hdl/sfr_front.sv
// Front end: accepts line bytes and restarts, strips escapes and hands
// classified operations to the back end. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front
   import sfr_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_push,
   input  logic       req_kind,
   input  logic [7:0] req_byte_value,
   output logic       req_full,
   output logic       item_push,
   output item_type   item,
   input  logic       item_full
);

   localparam int CntW = $clog2(PAYLOAD_BYTES + 1);

   phase_type       phase_ff, phase_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] cnt_step;
   logic            accept;
   logic            is_esc;
   logic            last_byte;

   assign req_full  = item_full;
   assign accept    = req_push && !item_full;
   assign is_esc    = (req_byte_value == cfg.start_byte) ||
                      (req_byte_value == cfg.stuff_byte);
   assign cnt_step  = cnt_ff + 1'b1;
   assign last_byte = (cnt_step == CntW'(PAYLOAD_BYTES));

   // Next framing phase and payload count
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         if (req_kind) begin
            phase_in = PH_COLLECT;
            cnt_in   = '0;
         end else begin
            case (phase_ff)
               PH_COLLECT: begin
                  if (is_esc) begin
                     phase_in = PH_ESCAPED;
                  end else begin
                     cnt_in   = cnt_step;
                     phase_in = last_byte ? PH_CHECKSUM : PH_COLLECT;
                  end
               end
               PH_ESCAPED: begin
                  cnt_in   = cnt_step;
                  phase_in = last_byte ? PH_CHECKSUM : PH_COLLECT;
               end
               PH_CHECKSUM: begin
                  phase_in = PH_DONE;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Build the operation for the back end; drop escapes and late bytes
   always_comb begin
      item_push    = 1'b0;
      item.op      = OP_DATA;
      item.data    = req_byte_value;
      item.slot    = SLOT_W'(cnt_ff);
      item.slot_ok = (int'(cnt_ff) < FIELD_BYTES);
      if (accept) begin
         if (req_kind) begin
            item_push = 1'b1;
            item.op   = OP_RESTART;
         end else begin
            case (phase_ff)
               PH_COLLECT: begin
                  item_push = !is_esc;
               end
               PH_ESCAPED: begin
                  item_push = 1'b1;
                  item.data = req_byte_value ^ cfg.xor_mask;
               end
               PH_CHECKSUM: begin
                  item_push = 1'b1;
                  item.op   = OP_CHECK;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COLLECT;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      item_push |-> accept)
      else $error("operation issued without an accepted transaction");

   a_done_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_kind && phase_ff == PH_DONE) |-> !item_push)
      else $error("byte after frame end was forwarded");

   a_check_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (item_push && item.op == OP_CHECK) |=> (phase_ff == PH_DONE))
      else $error("checksum issued but frame not closed");
`endif

endmodule

FILE: hdl/sfr_back.sv
// Back end: stores payload bytes, keeps the running sum and queues one
// result per checksum byte. Depends on sfr_pkg and sfr_fifo.
`timescale 1ns / 1ps

module sfr_back
   import sfr_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_empty,
   input  item_type    item,
   output logic        item_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_frame_ok,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_value_key,
   output logic [31:0] rsp_value_data,
   output logic [7:0]  rsp_got_checksum,
   output logic [7:0]  rsp_want_checksum
);

   localparam int SumW = $clog2(PAYLOAD_BYTES * 255 + 1);

   logic [SumW-1:0] sum_ff, sum_in;
   logic [7:0]      store_ff [FIELD_BYTES];
   logic [7:0]      view [FIELD_BYTES];
   logic            out_full;
   logic            out_push;
   result_type      result;
   result_type      rsp_data;

   // Take an operation unless a result is due and the output queue is full
   assign item_pop = !item_empty && !((item.op == OP_CHECK) && out_full);
   assign out_push = item_pop && (item.op == OP_CHECK);

   // Running sum: clear on restart, add on each payload byte
   always_comb begin
      sum_in = sum_ff;
      if (item_pop) begin
         case (item.op)
            OP_RESTART: sum_in = '0;
            OP_DATA:    sum_in = sum_ff + SumW'(item.data);
            default:    sum_in = sum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // Write payload bytes that appear in the result fields
   always_ff @(posedge clock) begin
      if (item_pop && item.op == OP_DATA && item.slot_ok) begin
         store_ff[item.slot] <= item.data;
      end
   end

   // Bytes beyond a short payload read as zero
   always_comb begin
      for (int k = 0; k < FIELD_BYTES; k++) begin
         view[k] = (k < PAYLOAD_BYTES) ? store_ff[k] : 8'h00;
      end
   end

   // Assemble the result
   always_comb begin
      result.want_checksum = checksum_of(16'(sum_ff));
      result.got_checksum  = item.data;
      result.frame_ok      = (result.want_checksum == item.data);
      result.frame_type    = view[0];
      result.value_key     = {view[2], view[1]};
      result.value_data    = {view[6], view[5], view[4], view[3]};
   end

   sfr_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (result),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

   assign rsp_frame_ok      = rsp_data.frame_ok;
   assign rsp_frame_type    = rsp_data.frame_type;
   assign rsp_value_key     = rsp_data.value_key;
   assign rsp_value_data    = rsp_data.value_data;
   assign rsp_got_checksum  = rsp_data.got_checksum;
   assign rsp_want_checksum = rsp_data.want_checksum;

`ifndef SYNTHESIS
   a_result_from_check: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (item_pop && item.op == OP_CHECK && !out_full))
      else $error("result queued without a checksum operation");

   a_restart_clears_sum: assert property (@(posedge clock) disable iff (reset)
      (item_pop && item.op == OP_RESTART) |=> (sum_ff == '0))
      else $error("running sum not cleared on restart");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (!item_empty && !item_pop) |-> out_full)
      else $error("operation held while the result queue had room");
`endif

endmodule

FILE: hdl/stuffed_frame_receiver_core.sv
// Top level of the stuffed frame receiver: control registers, front end,
// operation queue and back end. Depends on sfr_pkg, sfr_front, sfr_fifo, sfr_back.
`timescale 1ns / 1ps

// Byte-stuffed frame receiver. Push one line byte (req_kind low) or a restart
// (req_kind high) per cycle; the block sustains one transaction per clock
// while req_full is low. Escape bytes and bytes after a finished frame are
// absorbed in the front end and produce nothing. After PAYLOAD_BYTES payload
// bytes, the next raw byte is the checksum; the result (payload fields,
// received and computed checksum, match flag) reaches the rsp_ ports once the
// checksum operation has passed the queue between front and back end and the
// back end has written the result into the result queue.
// req_full rises only when results are not popped. Control registers
// (start byte, stuff byte, XOR mask) take a write every cycle and should
// only be changed while no frame is in flight.

module stuffed_frame_receiver_core
   import sfr_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_kind,
   input  logic [7:0]             req_byte_value,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_frame_ok,
   output logic [7:0]             rsp_frame_type,
   output logic [15:0]            rsp_value_key,
   output logic [31:0]            rsp_value_data,
   output logic [7:0]             rsp_got_checksum,
   output logic [7:0]             rsp_want_checksum
);

   cfg_type  cfg_ff, cfg_in;
   logic     item_push;
   item_type item_wr;
   logic     item_full;
   logic     item_pop;
   item_type item_rd;
   logic     item_empty;

   assign csr_ready = 1'b1;

   // Decode control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_BYTE: cfg_in.start_byte = csr_wdata;
            CSR_STUFF_BYTE: cfg_in.stuff_byte = csr_wdata;
            CSR_XOR_MASK:   cfg_in.xor_mask   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= START_BYTE_RST;
         cfg_ff.stuff_byte <= STUFF_BYTE_RST;
         cfg_ff.xor_mask   <= XOR_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfr_front #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_full       (req_full),
      .item_push      (item_push),
      .item           (item_wr),
      .item_full      (item_full)
   );

   sfr_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .wdata (item_wr),
      .full  (item_full),
      .pop   (item_pop),
      .rdata (item_rd),
      .empty (item_empty)
   );

   sfr_back #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_empty        (item_empty),
      .item              (item_rd),
      .item_pop          (item_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_value_key     (rsp_value_key),
      .rsp_value_data    (rsp_value_data),
      .rsp_got_checksum  (rsp_got_checksum),
      .rsp_want_checksum (rsp_want_checksum)
   );

endmodule

FILE: bench/stuffed_frame_receiver_core_tb.sv
// Self-checking bench for stuffed_frame_receiver_core: stuffed byte streams and restarts
// go in, decoded frames are checked field by field against a frame decoder model.
// Depends on sfr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

import sfr_pkg::*;

localparam logic KIND_BYTE    = 1'b0;
localparam logic KIND_RESTART = 1'b1;

typedef enum int {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_type;
typedef enum int {ROUTE_AUTO, ROUTE_PLAIN, ROUTE_START, ROUTE_STUFF} route_type;

// Frame decoder model plus the queue of decoded frames still owed by the block
class frame_scoreboard;
   localparam int REPORT_LIMIT = 10;
   localparam int STORE_DEPTH  = 16;

   result_type  pending_frames[$];
   logic [7:0]  start_val;
   logic [7:0]  stuff_val;
   logic [7:0]  mask_val;
   phase_type   ph;
   int unsigned taken;
   logic [7:0]  payload [STORE_DEPTH];
   logic [15:0] sum;
   int          mismatches;

   function new();
      start_val  = START_BYTE_RST;
      stuff_val  = STUFF_BYTE_RST;
      mask_val   = XOR_MASK_RST;
      ph         = PH_COLLECT;
      taken      = 0;
      sum        = '0;
      mismatches = 0;
      foreach (payload[i]) payload[i] = '0;
   endfunction

   function void write_reg(csr_index_type idx, logic [7:0] v);
      case (idx)
         CSR_START_BYTE: start_val = v;
         CSR_STUFF_BYTE: stuff_val = v;
         CSR_XOR_MASK:   mask_val  = v;
         default: ;
      endcase
   endfunction

   // Complement of the sum with its carry byte folded back in
   function logic [7:0] checksum_now();
      logic [7:0] fold;
      fold = sum[7:0] + sum[15:8];
      return ~fold;
   endfunction

   function logic [7:0] field_byte(int unsigned i);
      if (i >= PAYLOAD_BYTES_DEF || i >= STORE_DEPTH) return 8'h00;
      return payload[i];
   endfunction

   function void keep_byte(logic [7:0] b);
      if (taken < STORE_DEPTH) payload[taken] = b;
      sum   = sum + 16'(b);
      taken = taken + 1;
      ph    = (taken >= PAYLOAD_BYTES_DEF) ? PH_CHECKSUM : PH_COLLECT;
   endfunction

   // Advance on one accepted transaction; returns 0 when the block ignores it
   function bit take_line_item(logic kind, logic [7:0] b);
      result_type r;
      if (kind == KIND_RESTART) begin
         ph    = PH_COLLECT;
         taken = 0;
         sum   = '0;
         return 1'b1;
      end
      case (ph)
         PH_COLLECT: begin
            if (b == start_val || b == stuff_val) ph = PH_ESCAPED;
            else keep_byte(b);
         end
         PH_ESCAPED: keep_byte(b ^ mask_val);
         PH_CHECKSUM: begin
            r.want_checksum = checksum_now();
            r.got_checksum  = b;
            r.frame_ok      = (b == r.want_checksum);
            r.frame_type    = field_byte(0);
            r.value_key     = {field_byte(2), field_byte(1)};
            r.value_data    = {field_byte(6), field_byte(5), field_byte(4), field_byte(3)};
            pending_frames.push_back(r);
            ph = PH_DONE;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Match one popped frame against the oldest owed one
   function void check_frame(result_type got);
      result_type want;
      if (pending_frames.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t unexpected frame result %h", $time, got);
         return;
      end
      want = pending_frames.pop_front();
      compare_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
      compare_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
      compare_field("value_key", 32'(want.value_key), 32'(got.value_key));
      compare_field("value_data", want.value_data, got.value_data);
      compare_field("got_checksum", 32'(want.got_checksum), 32'(got.got_checksum));
      compare_field("want_checksum", 32'(want.want_checksum), 32'(got.want_checksum));
   endfunction
endclass

module stuffed_frame_receiver_core_tb;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 16;
   localparam int ITEM_TARGET  = 1950;
   localparam int NUM_SETTINGS = 6;
   localparam int LIMIT_NS     = 2_000_000;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [7:0]             csr_wdata      = '0;
   logic                   req_push       = 1'b0;
   logic                   req_full;
   logic                   req_kind       = 1'b0;
   logic [7:0]             req_byte_value = '0;
   logic                   rsp_empty;
   logic                   rsp_pop        = 1'b0;
   logic                   rsp_frame_ok;
   logic [7:0]             rsp_frame_type;
   logic [15:0]            rsp_value_key;
   logic [31:0]            rsp_value_data;
   logic [7:0]             rsp_got_checksum;
   logic [7:0]             rsp_want_checksum;

   frame_scoreboard sb;
   int              items_done = 0;

   stuffed_frame_receiver_core #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES_DEF)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_byte_value   (req_byte_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_value_key    (rsp_value_key),
      .rsp_value_data   (rsp_value_data),
      .rsp_got_checksum (rsp_got_checksum),
      .rsp_want_checksum(rsp_want_checksum)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int gap_len(pace_type pace);
      int r;
      r = $urandom_range(0, 99);
      case (pace)
         PACE_STEADY: return 0;
         PACE_LIGHT:
            return (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(6, 30);
         default:
            return (r < 30) ? 0 : (r < 80) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      endcase
   endfunction

   // Drive one transaction after an optional gap and hold it until accepted
   task automatic push_item(logic kind, logic [7:0] b, pace_type pace);
      int n;
      n = gap_len(pace);
      if (n > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push       <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= b;
      do @(posedge clock); while (req_full);
      if (sb.take_line_item(kind, b)) items_done++;
   endtask

   // Send one payload byte, escaped where needed, at random, or where the route asks
   task automatic send_payload(logic [7:0] p, pace_type pace, route_type route);
      if (route == ROUTE_AUTO) begin
         if (p == sb.start_val || p == sb.stuff_val || $urandom_range(0, 9) == 0)
            route = ($urandom_range(0, 1) != 0) ? ROUTE_START : ROUTE_STUFF;
         else
            route = ROUTE_PLAIN;
      end
      case (route)
         ROUTE_START: push_item(KIND_BYTE, sb.start_val, pace);
         ROUTE_STUFF: push_item(KIND_BYTE, sb.stuff_val, pace);
         default: ;
      endcase
      push_item(KIND_BYTE, (route == ROUTE_PLAIN) ? p : p ^ sb.mask_val, pace);
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold the sender until every owed frame is out, then let the pipe empty
   task automatic drain_frames();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int setting);
      logic [7:0] esc;
      esc = 8'($urandom);
      case (setting)
         1: begin
            write_csr(CSR_START_BYTE, 8'h00);
            write_csr(CSR_STUFF_BYTE, 8'hFF);
            write_csr(CSR_XOR_MASK, 8'hFF);
         end
         2: begin
            write_csr(CSR_START_BYTE, 8'hFF);
            write_csr(CSR_STUFF_BYTE, 8'h00);
            write_csr(CSR_XOR_MASK, 8'h00);
         end
         3: begin
            // one escape value shared by both registers
            write_csr(CSR_START_BYTE, esc);
            write_csr(CSR_STUFF_BYTE, esc);
            write_csr(CSR_XOR_MASK, 8'($urandom));
         end
         4: begin
            write_csr(CSR_START_BYTE, 8'($urandom));
            write_csr(CSR_STUFF_BYTE, 8'($urandom));
            write_csr(CSR_XOR_MASK, 8'($urandom));
         end
         default: begin
            write_csr(CSR_START_BYTE, START_BYTE_RST);
            write_csr(CSR_STUFF_BYTE, STUFF_BYTE_RST);
            write_csr(CSR_XOR_MASK, XOR_MASK_RST);
         end
      endcase
   endtask

   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 9))
         0: return sb.start_val;
         1: return sb.stuff_val;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      // clean frame: both escape routes, byte extremes, a byte after completion
      push_item(KIND_RESTART, 8'hFF, PACE_LIGHT);
      send_payload(8'h00, PACE_LIGHT, ROUTE_PLAIN);
      send_payload(START_BYTE_RST, PACE_LIGHT, ROUTE_STUFF);
      send_payload(STUFF_BYTE_RST, PACE_LIGHT, ROUTE_START);
      send_payload(8'hFF, PACE_LIGHT, ROUTE_PLAIN);
      send_payload(8'h80, PACE_LIGHT, ROUTE_PLAIN);
      send_payload(8'h01, PACE_LIGHT, ROUTE_PLAIN);
      send_payload(8'hA5, PACE_LIGHT, ROUTE_PLAIN);
      push_item(KIND_BYTE, sb.checksum_now(), PACE_LIGHT);
      push_item(KIND_BYTE, START_BYTE_RST, PACE_LIGHT);
      // restart in the middle of a frame
      push_item(KIND_RESTART, 8'h00, PACE_STEADY);
      push_item(KIND_BYTE, 8'h11, PACE_STEADY);
      push_item(KIND_BYTE, 8'h22, PACE_STEADY);
      push_item(KIND_BYTE, 8'h33, PACE_STEADY);
      push_item(KIND_RESTART, 8'h5A, PACE_STEADY);
      // all-ones payload, checksum byte raw and equal to the start value
      repeat (7) send_payload(8'hFF, PACE_STEADY, ROUTE_PLAIN);
      push_item(KIND_BYTE, START_BYTE_RST, PACE_STEADY);
   endtask

   // Mostly well-formed frames, plus noise, cut frames and frames without restart
   task automatic send_random_frame();
      pace_type   pace;
      int         mode;
      int         cut;
      logic [7:0] ck;
      pace = pace_type'($urandom_range(0, 2));
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
         repeat ($urandom_range(1, 6))
            push_item(($urandom_range(0, 6) == 0), 8'($urandom), pace);
         return;
      end
      if (mode >= 12) push_item(KIND_RESTART, 8'($urandom), pace);
      cut = (mode < 22) ? $urandom_range(0, PAYLOAD_BYTES_DEF - 1) : PAYLOAD_BYTES_DEF;
      repeat (cut) send_payload(pick_payload(), pace, ROUTE_AUTO);
      if (cut < PAYLOAD_BYTES_DEF) return;
      case ($urandom_range(0, 7))
         0: ck = 8'($urandom);
         1: ck = sb.start_val;
         default: ck = sb.checksum_now();
      endcase
      push_item(KIND_BYTE, ck, pace);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) push_item(KIND_BYTE, 8'($urandom), pace);
   endtask

   // Drive pop with stalls whose pace changes now and then
   initial begin : pop_driver
      int       stall;
      pace_type pace;
      stall = 0;
      pace  = PACE_LIGHT;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) pace = pace_type'($urandom_range(0, 2));
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            stall = gap_len(pace);
         end
      end
   end

   // Check every popped transaction
   always @(posedge clock) begin : result_monitor
      result_type seen;
      if (!reset && rsp_pop && !rsp_empty) begin
         seen.frame_ok      = rsp_frame_ok;
         seen.frame_type    = rsp_frame_type;
         seen.value_key     = rsp_value_key;
         seen.value_data    = rsp_value_data;
         seen.got_checksum  = rsp_got_checksum;
         seen.want_checksum = rsp_want_checksum;
         sb.check_frame(seen);
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain_frames();
         configure(s);
         while (items_done < ITEM_TARGET * (s + 1) / NUM_SETTINGS) send_random_frame();
      end
      drain_frames();
      if (sb.mismatches == 0 && sb.pending_frames.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
